// ----- hdl/pfa_pkg.sv -----
// Shared types and constants for the page frame allocator MMU.
// Used by pfa_ctrl, pfa_dpath and page_frame_allocator_mmu; no dependencies.
`default_nettype none

package pfa_pkg;

	localparam int PAGE_COUNT = 512;
	localparam int PAGE_SHIFT = 12;
	localparam int FRAME_W    = $clog2(PAGE_COUNT);
	localparam int VPN_W      = $clog2(PAGE_COUNT);
	localparam int PA_W       = FRAME_W + PAGE_SHIFT;
	localparam int COUNT_W    = 10;
	localparam int RSV_W      = 10;

	localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
	localparam logic [31:0]        STACK_GAP  = 32'd8;
	localparam logic [1:0]         ALIGN_MASK = 2'b11;

	// operation codes
	localparam logic [2:0] OP_INIT      = 3'd0;
	localparam logic [2:0] OP_TRANSLATE = 3'd1;
	localparam logic [2:0] OP_FAULT     = 3'd2;
	localparam logic [2:0] OP_ALLOC     = 3'd3;
	localparam logic [2:0] OP_FREE      = 3'd4;

	// status codes
	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_RANGE      = 3'd1;
	localparam logic [2:0] ST_MISALIGNED = 3'd2;
	localparam logic [2:0] ST_UNMAPPED   = 3'd3;
	localparam logic [2:0] ST_MAPPED     = 3'd4;
	localparam logic [2:0] ST_NO_MEM     = 3'd5;
	localparam logic [2:0] ST_SEGFAULT   = 3'd6;
	localparam logic [2:0] ST_NOT_IN_USE = 3'd7;

	typedef struct packed {
		logic [2:0]  operation;
		logic [31:0] virtual_address;
		logic [31:0] stack_pointer;
		logic [8:0]  page_to_free;
	} in_t;

	typedef struct packed {
		logic [2:0]         status;
		logic               kill_process;
		logic [PA_W-1:0]    physical_address;
		logic [FRAME_W-1:0] frame_number;
		logic [COUNT_W-1:0] mapped_count;
	} out_t;

	typedef struct packed {
		logic               valid;
		logic [FRAME_W-1:0] frame;
	} pte_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic init_map;
		logic clr_step;
		logic pt_rd;
		logic lookup;
		logic scan_step;
		logic free_op;
		logic out_load;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [2:0] op;
		logic       clr_last;
		logic       need_scan;
		logic       scan_done;
		logic       out_busy;
	} sts_t;

endpackage

`default_nettype wire

// ----- hdl/page_frame_allocator_mmu.sv -----
// Top level of the page frame allocator MMU: controller plus datapath.
// Depends on pfa_pkg, pfa_ctrl and pfa_dpath.
//
// One-level MMU with 4 KB pages, 512 virtual pages and 512 physical frames.
// One word is worked at a time; a new word is taken while the previous result
// still waits in the output register. Alloc, and a fault that needs a frame,
// read the bitmap one word per cycle through the scan unit until a word with a
// free frame or the last word (PAGE_COUNT / MAP_WORD_BITS words, 16 by default).
// Init clears the page table, a single-port memory, one entry per cycle. After
// reset the same clearing pass runs with in_ready low; cfg writes are taken
// throughout.
`default_nettype none

module page_frame_allocator_mmu
	import pfa_pkg::*;
#(
	parameter int MAP_WORD_BITS = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  in_t                   in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output out_t                  out_data,
	input  wire logic             cfg_we,
	input  wire logic [RSV_W-1:0] cfg_wdata
);

	cmd_t cmd;
	sts_t sts;

	pfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	pfa_dpath #(
		.MAP_WORD_BITS (MAP_WORD_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

`default_nettype wire

// ----- hdl/pfa_ctrl.sv -----
// Sequencing state machine for the page frame allocator MMU.
// Depends on pfa_pkg; drives pfa_dpath through cmd_t and reads sts_t.
`default_nettype none

module pfa_ctrl
	import pfa_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output cmd_t      cmd,
	input  sts_t      sts
);

	localparam logic [2:0] S_RCLR = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_DEC  = 3'd2;
	localparam logic [2:0] S_ICLR = 3'd3;
	localparam logic [2:0] S_LOOK = 3'd4;
	localparam logic [2:0] S_SCAN = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_RCLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				cmd.load = in_valid;
				if (in_valid) state_d = S_DEC;
			end
			S_DEC: begin
				unique case (sts.op) inside
					OP_INIT: begin
						cmd.init_map = 1'b1;
						state_d      = S_ICLR;
					end
					OP_TRANSLATE, OP_FAULT: begin
						cmd.pt_rd = 1'b1;
						state_d   = S_LOOK;
					end
					OP_ALLOC: state_d = S_SCAN;
					OP_FREE: begin
						cmd.free_op = 1'b1;
						state_d     = S_DONE;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_ICLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) state_d = S_DONE;
			end
			S_LOOK: begin
				cmd.lookup = 1'b1;
				state_d    = sts.need_scan ? S_SCAN : S_DONE;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) state_d = S_DONE;
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_RCLR;
		else         state_q <= state_d;
	end

	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clr_step, cmd.pt_rd, cmd.lookup, cmd.scan_step, cmd.free_op}))
		else $error("more than one datapath unit commanded");

	a_accept_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_DEC))
		else $error("accepted word not decoded");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !sts.out_busy)
		else $error("result register overwritten");

	a_scan_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && sts.scan_done) |=> (state_q == S_DONE))
		else $error("scan did not finish");

endmodule

`default_nettype wire

// ----- hdl/pfa_dpath.sv -----
// Datapath: item register, page table memory, frame bitmap, scan unit and result register.
// Depends on pfa_pkg; commanded by pfa_ctrl.
`default_nettype none

module pfa_dpath
	import pfa_pkg::*;
#(
	parameter int MAP_WORD_BITS = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  in_t                   in_data,
	output out_t                  out_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	input  wire logic             cfg_we,
	input  wire logic [RSV_W-1:0] cfg_wdata,
	input  cmd_t                  cmd,
	output sts_t                  sts
);

	localparam int MAP_WORDS = (PAGE_COUNT + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
	localparam int MAP_BITS  = MAP_WORDS * MAP_WORD_BITS;
	localparam int MAP_IDX_W = $clog2(MAP_BITS);
	localparam int SCAN_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int ENC_W     = $clog2(MAP_WORD_BITS);

	logic [RSV_W-1:0]   reserved_q;
	in_t                item_q;
	pte_t               pt_mem [PAGE_COUNT];
	pte_t               pt_rd_q;
	logic [VPN_W-1:0]   clr_addr_q;
	// bits at or above PAGE_COUNT pad the last word and always read as busy
	logic [MAP_BITS-1:0] map_q;
	logic [SCAN_W-1:0]  scan_idx_q;
	logic [COUNT_W-1:0] count_q;
	logic [2:0]         status_q;
	logic [PA_W-1:0]    pa_q;
	logic [FRAME_W-1:0] frame_q;
	out_t               out_q;
	logic               out_valid_q;

	logic [31:0]              vpn_full;
	logic [VPN_W-1:0]         vpn;
	logic                     in_range;
	logic                     above_stack;
	logic [2:0]               lk_status;
	logic [PA_W-1:0]          lk_pa;
	logic [MAP_WORD_BITS-1:0] free_vec;
	logic                     any_free;
	logic [ENC_W-1:0]         enc;
	logic [31:0]              found_full;
	logic [MAP_IDX_W-1:0]     found_idx;
	logic                     last_word;
	logic                     free_ok;
	logic                     kill;

	// ---- address checks on the held item ----
	assign vpn_full    = item_q.virtual_address >> PAGE_SHIFT;
	assign vpn         = vpn_full[VPN_W-1:0];
	assign in_range    = vpn_full < 32'(PAGE_COUNT);
	assign above_stack = vpn_full >= ((item_q.stack_pointer - STACK_GAP) >> PAGE_SHIFT);

	always_comb begin
		lk_status = ST_OK;
		lk_pa     = '0;
		if (item_q.operation == OP_TRANSLATE) begin
			if (!in_range)                                     lk_status = ST_RANGE;
			else if ((item_q.virtual_address[1:0] & ALIGN_MASK) != 2'b00)
				lk_status = ST_MISALIGNED;
			else if (!pt_rd_q.valid)                           lk_status = ST_UNMAPPED;
			else lk_pa = {pt_rd_q.frame, item_q.virtual_address[PAGE_SHIFT-1:0]};
		end else begin
			if (!in_range)          lk_status = ST_RANGE;
			else if (!above_stack)  lk_status = ST_SEGFAULT;
			else if (pt_rd_q.valid) lk_status = ST_MAPPED;
		end
	end

	// ---- lowest free frame in the current bitmap word ----
	assign free_vec = ~map_q[32'(scan_idx_q) * MAP_WORD_BITS +: MAP_WORD_BITS];
	assign any_free = |free_vec;

	always_comb begin
		enc = '0;
		for (int b = MAP_WORD_BITS - 1; b >= 0; b--) begin
			if (free_vec[b]) enc = ENC_W'(b);
		end
	end

	assign found_full = 32'(scan_idx_q) * 32'(MAP_WORD_BITS) + 32'(enc);
	assign found_idx  = found_full[MAP_IDX_W-1:0];
	assign last_word  = (scan_idx_q == SCAN_W'(MAP_WORDS - 1));

	assign free_ok = map_q[MAP_IDX_W'(item_q.page_to_free)] &&
		(32'(item_q.page_to_free) < 32'(PAGE_COUNT));

	// ---- status back to the controller ----
	assign sts.op        = item_q.operation;
	assign sts.clr_last  = (clr_addr_q == VPN_W'(PAGE_COUNT - 1));
	assign sts.need_scan = (item_q.operation == OP_FAULT) && (lk_status == ST_OK);
	assign sts.scan_done = any_free || last_word;
	assign sts.out_busy  = out_valid_q && !out_ready;

	// ---- configuration ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)     reserved_q <= '0;
		else if (cfg_we) reserved_q <= cfg_wdata;
	end

	// ---- item and working result ----
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q   <= in_data;
			status_q <= ST_OK;
			pa_q     <= '0;
			frame_q  <= '0;
		end
		if (cmd.lookup) begin
			status_q <= lk_status;
			pa_q     <= lk_pa;
		end
		if (cmd.scan_step) begin
			if (any_free)       frame_q  <= found_full[FRAME_W-1:0];
			else if (last_word) status_q <= ST_NO_MEM;
		end
		if (cmd.free_op && !free_ok) status_q <= ST_NOT_IN_USE;
	end

	// ---- page table ----
	always_ff @(posedge clk) begin
		if (cmd.clr_step)
			pt_mem[clr_addr_q] <= '0;
		else if (cmd.scan_step && any_free && item_q.operation == OP_FAULT)
			pt_mem[vpn] <= '{valid: 1'b1, frame: found_full[FRAME_W-1:0]};
		if (cmd.pt_rd) pt_rd_q <= pt_mem[vpn];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_addr_q <= sts.clr_last ? '0 : clr_addr_q + 1'b1;
		end
	end

	// ---- frame bitmap, scan pointer, mapped count ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAP_BITS; i++) map_q[i] <= (i >= PAGE_COUNT);
			scan_idx_q <= '0;
			count_q    <= '0;
		end else begin
			if (cmd.load) scan_idx_q <= '0;
			if (cmd.init_map) begin
				for (int i = 0; i < MAP_BITS; i++)
					map_q[i] <= (i >= PAGE_COUNT) || (32'(i) < 32'(reserved_q));
				count_q <= '0;
			end
			if (cmd.scan_step) begin
				if (any_free) begin
					map_q[found_idx] <= 1'b1;
					if (item_q.operation == OP_FAULT && count_q != COUNT_MAX)
						count_q <= count_q + 1'b1;
				end else if (!last_word) begin
					scan_idx_q <= scan_idx_q + 1'b1;
				end
			end
			if (cmd.free_op && free_ok) map_q[MAP_IDX_W'(item_q.page_to_free)] <= 1'b0;
		end
	end

	// ---- result register ----
	assign kill = (status_q == ST_MISALIGNED) ||
		((item_q.operation == OP_FAULT) &&
		 (status_q == ST_RANGE || status_q == ST_NO_MEM || status_q == ST_SEGFAULT));

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.status           <= status_q;
			out_q.kill_process     <= kill;
			out_q.physical_address <= pa_q;
			out_q.frame_number     <= frame_q;
			out_q.mapped_count     <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)           out_valid_q <= 1'b0;
		else if (cmd.out_load) out_valid_q <= 1'b1;
		else if (out_ready)    out_valid_q <= 1'b0;
	end

	assign out_data  = out_q;
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ----- test/page_frame_allocator_mmu_test.sv -----
// Self-checking testbench for page_frame_allocator_mmu: directed table, then random phases.
// Depends on pfa_pkg and the page_frame_allocator_mmu RTL; prediction is done locally.
`timescale 1ns / 1ps

module page_frame_allocator_mmu_test
	import pfa_pkg::*;
();

	localparam logic [2:0] OP_UNUSED_FIRST = OP_FREE + 3'd1;
	localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;
	localparam int WATCHDOG_LIMIT  = 5000;
	localparam int HOLD_CYCLES     = 400;
	localparam int SETTLE_CYCLES   = 600;
	localparam int PHASES          = 6;
	localparam int WORDS_PER_PHASE = 305;
	localparam int REPORT_LIMIT    = 10;

	typedef struct {
		bit               set_reserved;
		logic [RSV_W-1:0] reserved_val;
		in_t              word;
		bit               typed;
		out_t             want;
	} stim_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	in_t              in_data = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	out_t             out_data;
	logic             cfg_we = 1'b0;
	logic [RSV_W-1:0] cfg_wdata = '0;

	// shadow of the block's state
	logic [RSV_W-1:0]      reserved_count = '0;
	logic [PAGE_COUNT-1:0] frame_busy = '0;
	logic [PAGE_COUNT-1:0] pte_valid = '0;
	logic [FRAME_W-1:0]    pte_frame [PAGE_COUNT];
	logic [COUNT_W-1:0]    mapped_pages = '0;

	out_t      pending_results [$];
	stim_row_t directed_rows [$];
	int        error_count = 0;
	int        words_sent = 0;
	int        results_checked = 0;
	int        status_hits [8];
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	int        recv_hold = 0;
	int        idle_cycles = 0;

	page_frame_allocator_mmu uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// lowest free frame is marked busy; -1 when the map is full
	function automatic int take_lowest_frame();
		for (int f = 0; f < PAGE_COUNT; f++) begin
			if (!frame_busy[f]) begin
				frame_busy[f] = 1'b1;
				return f;
			end
		end
		return -1;
	endfunction

	function automatic out_t predict_mmu_result(in_t w);
		out_t        r;
		logic [31:0] vpage;
		logic [31:0] stack_page;
		int          f;
		int          n;
		r = '0;
		vpage = w.virtual_address >> PAGE_SHIFT;
		case (w.operation)
			OP_INIT: begin
				frame_busy = '0;
				pte_valid = '0;
				mapped_pages = '0;
				n = (reserved_count > PAGE_COUNT) ? PAGE_COUNT : reserved_count;
				for (int i = 0; i < n; i++)
					frame_busy[i] = 1'b1;
			end
			OP_TRANSLATE: begin
				if (vpage >= PAGE_COUNT) begin
					r.status = ST_RANGE;
				end else if ((w.virtual_address[1:0] & ALIGN_MASK) != 0) begin
					r.status = ST_MISALIGNED;
					r.kill_process = 1'b1;
				end else if (!pte_valid[vpage]) begin
					r.status = ST_UNMAPPED;
				end else begin
					r.physical_address = {pte_frame[vpage], w.virtual_address[PAGE_SHIFT-1:0]};
				end
			end
			OP_FAULT: begin
				// stack pointer below the gap wraps, putting the stack page out of reach
				stack_page = (w.stack_pointer - STACK_GAP) >> PAGE_SHIFT;
				if (vpage >= PAGE_COUNT) begin
					r.status = ST_RANGE;
					r.kill_process = 1'b1;
				end else if (vpage >= stack_page) begin
					if (pte_valid[vpage]) begin
						r.status = ST_MAPPED;
					end else begin
						f = take_lowest_frame();
						if (f < 0) begin
							r.status = ST_NO_MEM;
							r.kill_process = 1'b1;
						end else begin
							r.frame_number = FRAME_W'(f);
							pte_valid[vpage] = 1'b1;
							pte_frame[vpage] = FRAME_W'(f);
							if (mapped_pages != COUNT_MAX)
								mapped_pages++;
						end
					end
				end else begin
					r.status = ST_SEGFAULT;
					r.kill_process = 1'b1;
				end
			end
			OP_ALLOC: begin
				f = take_lowest_frame();
				if (f < 0)
					r.status = ST_NO_MEM;
				else
					r.frame_number = FRAME_W'(f);
			end
			OP_FREE: begin
				if (w.page_to_free < PAGE_COUNT && frame_busy[w.page_to_free])
					frame_busy[w.page_to_free] = 1'b0;
				else
					r.status = ST_NOT_IN_USE;
			end
			default: ;
		endcase
		r.mapped_count = mapped_pages;
		return r;
	endfunction

	function automatic in_t word_of(logic [2:0] op, logic [31:0] va, logic [31:0] sp,
			logic [8:0] pf);
		in_t w;
		w.operation = op;
		w.virtual_address = va;
		w.stack_pointer = sp;
		w.page_to_free = pf;
		return w;
	endfunction

	function automatic void queue_word(in_t w);
		stim_row_t row;
		row = '{set_reserved: 1'b0, reserved_val: '0, word: w, typed: 1'b0, want: '0};
		directed_rows.push_back(row);
	endfunction

	// address and frame are zero in every hand-written result
	function automatic void queue_checked(in_t w, logic [2:0] st, logic kill,
			logic [COUNT_W-1:0] cnt);
		stim_row_t row;
		out_t      r;
		r = '0;
		r.status = st;
		r.kill_process = kill;
		r.mapped_count = cnt;
		row = '{set_reserved: 1'b0, reserved_val: '0, word: w, typed: 1'b1, want: r};
		directed_rows.push_back(row);
	endfunction

	function automatic void queue_reserved(logic [RSV_W-1:0] v);
		stim_row_t row;
		row = '{set_reserved: 1'b1, reserved_val: v, word: '0, typed: 1'b0, want: '0};
		directed_rows.push_back(row);
	endfunction

	function automatic in_t random_word();
		in_t         w;
		int          pick;
		int          sel;
		logic [31:0] base;
		w.operation = OP_ALLOC;
		w.virtual_address = $urandom;
		w.stack_pointer = $urandom;
		w.page_to_free = 9'($urandom);
		// most pages come from a narrow window so faults and translates meet
		if ($urandom_range(99) < 60)
			base = 32'($urandom_range(63)) << PAGE_SHIFT;
		else
			base = 32'($urandom_range(PAGE_COUNT - 1)) << PAGE_SHIFT;
		pick = $urandom_range(99);
		if (pick < 1) begin
			w.operation = OP_INIT;
		end else if (pick < 36) begin
			w.operation = OP_TRANSLATE;
			sel = $urandom_range(99);
			if (sel < 85)
				w.virtual_address = base | ($urandom_range(4095) & ~32'(ALIGN_MASK));
			else if (sel < 93)
				w.virtual_address = base | $urandom_range(4095);
		end else if (pick < 66) begin
			w.operation = OP_FAULT;
			if ($urandom_range(99) < 88)
				w.virtual_address = base | $urandom_range(4095);
			sel = $urandom_range(99);
			if (sel < 60)
				w.stack_pointer = base + $urandom_range((1 << PAGE_SHIFT) + STACK_GAP - 1);
			else if (sel < 70)
				w.stack_pointer = $urandom_range(base);
			else if (sel < 80)
				w.stack_pointer = $urandom_range(STACK_GAP - 1);
		end else if (pick < 80) begin
			w.operation = OP_ALLOC;
		end else if (pick < 95) begin
			w.operation = OP_FREE;
			if ($urandom_range(99) < 60)
				w.page_to_free = 9'($urandom_range(63));
		end else begin
			w.operation = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
		end
		return w;
	endfunction

	task automatic send_word(input in_t w, input bit typed, input out_t want);
		out_t predicted;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (!in_ready);
		predicted = predict_mmu_result(w);
		pending_results.push_back(typed ? want : predicted);
		words_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic write_reserved(input logic [RSV_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		reserved_count = v;
	endtask

	// receiver: random stalls, or a long hold-off counted down here
	always @(posedge clk) begin
		if (recv_hold > 0) begin
			out_ready <= 1'b0;
			recv_hold <= recv_hold - 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin : check_results
		out_t want;
		if (arst_n && out_valid && out_ready) begin
			status_hits[out_data.status]++;
			results_checked++;
			if (pending_results.size() == 0) begin
				error_count++;
				if (error_count <= REPORT_LIMIT)
					$display("unexpected word: st %0d kill %0d pa %h frame %0d cnt %0d",
						out_data.status, out_data.kill_process, out_data.physical_address,
						out_data.frame_number, out_data.mapped_count);
			end else begin
				want = pending_results.pop_front();
				if (out_data !== want) begin
					error_count++;
					if (error_count <= REPORT_LIMIT) begin
						$display("mismatch %0d: expected st %0d kill %0d pa %h frame %0d cnt %0d",
							results_checked, want.status, want.kill_process,
							want.physical_address, want.frame_number, want.mapped_count);
						$display("         got st %0d kill %0d pa %h frame %0d cnt %0d",
							out_data.status, out_data.kill_process, out_data.physical_address,
							out_data.frame_number, out_data.mapped_count);
					end
				end
			end
		end
	end

	// counts cycles in which no word moves on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles, %0d results outstanding",
				WATCHDOG_LIMIT, pending_results.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		logic [RSV_W-1:0] rsv;
		for (int i = 0; i < PAGE_COUNT; i++)
			pte_frame[i] = '0;
		for (int i = 0; i < 8; i++)
			status_hits[i] = 0;

		// directed: reset state, every operation, range/alignment/stack corner cases
		queue_reserved(10'd3);
		queue_checked(word_of(OP_TRANSLATE, 32'h0, 32'h0, 9'h0), ST_UNMAPPED, 1'b0, 10'd0);
		queue_checked(word_of(OP_INIT, 32'h0, 32'h0, 9'h0), ST_OK, 1'b0, 10'd0);
		queue_checked(word_of(OP_TRANSLATE, 32'hFFFF_FFFF, 32'h0, 9'h0), ST_RANGE, 1'b0, 10'd0);
		queue_checked(word_of(OP_TRANSLATE, 32'h0000_1002, 32'h0, 9'h0),
			ST_MISALIGNED, 1'b1, 10'd0);
		queue_checked(word_of(OP_TRANSLATE, 32'h001F_F001, 32'h0, 9'h0),
			ST_MISALIGNED, 1'b1, 10'd0);
		queue_checked(word_of(OP_FAULT, 32'hFFFF_F000, 32'h0, 9'h0), ST_RANGE, 1'b1, 10'd0);
		queue_word(word_of(OP_FAULT, 32'h0000_1000, 32'h0000_1008, 9'h0));
		queue_word(word_of(OP_TRANSLATE, 32'h0000_1FFC, 32'h0, 9'h0));
		queue_word(word_of(OP_FAULT, 32'h0000_1000, 32'h0000_1008, 9'h0));
		queue_checked(word_of(OP_FAULT, 32'h0, 32'h0000_2008, 9'h0), ST_SEGFAULT, 1'b1, 10'd1);
		// stack pointer under the gap wraps, so even the top page segfaults
		queue_checked(word_of(OP_FAULT, 32'h001F_F000, 32'h4, 9'h0), ST_SEGFAULT, 1'b1, 10'd1);
		queue_word(word_of(OP_FAULT, 32'h001F_FFFC, 32'h001F_F008, 9'h0));
		queue_word(word_of(OP_ALLOC, 32'h0, 32'h0, 9'h0));
		queue_checked(word_of(OP_FREE, 32'h0, 32'h0, 9'h1FF), ST_NOT_IN_USE, 1'b0, 10'd2);
		queue_checked(word_of(OP_FREE, 32'h0, 32'h0, 9'h0), ST_OK, 1'b0, 10'd2);
		queue_checked(word_of(OP_FREE, 32'h0, 32'h0, 9'h0), ST_NOT_IN_USE, 1'b0, 10'd2);
		queue_word(word_of(OP_ALLOC, 32'h0, 32'h0, 9'h0));
		queue_checked(word_of(OP_UNUSED_FIRST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'h1FF),
			ST_OK, 1'b0, 10'd2);
		// reserved count beyond the frame total fills the whole map
		queue_reserved(10'h3FF);
		queue_checked(word_of(OP_INIT, 32'h0, 32'h0, 9'h0), ST_OK, 1'b0, 10'd0);
		queue_checked(word_of(OP_FAULT, 32'h0000_3000, 32'h0000_3000, 9'h0),
			ST_NO_MEM, 1'b1, 10'd0);
		queue_checked(word_of(OP_ALLOC, 32'h0, 32'h0, 9'h0), ST_NO_MEM, 1'b0, 10'd0);
		queue_reserved(10'd0);
		queue_checked(word_of(OP_INIT, 32'h0, 32'h0, 9'h0), ST_OK, 1'b0, 10'd0);
		queue_checked(word_of(OP_ALLOC, 32'h0, 32'h0, 9'h0), ST_OK, 1'b0, 10'd0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].set_reserved) begin
				drain_results();
				write_reserved(directed_rows[i].reserved_val);
			end else begin
				send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			drain_results();
			case (p)
				0: rsv = 10'd0;
				1: rsv = 10'd512;
				2: rsv = RSV_W'($urandom_range(1, 100));
				3: rsv = 10'h3FF;
				4: rsv = 10'd511;
				default: rsv = RSV_W'($urandom);
			endcase
			write_reserved(rsv);
			case (p)
				1: begin send_idle_pct = 62; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 62; end
				3, 5: begin send_idle_pct = 33; recv_stall_pct = 33; end
				default: begin send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			send_word(word_of(OP_INIT, $urandom, $urandom, 9'($urandom)), 1'b0, '0);
			for (int i = 0; i < WORDS_PER_PHASE; i++) begin
				if (p == 4 && i == 100)
					recv_hold <= HOLD_CYCLES;   // input backs up while the sink holds off
				if (p == 4 && i == 200)
					drain_results();
				send_word(random_word(), 1'b0, '0);
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			error_count++;
			$display("%0d expected results never arrived", pending_results.size());
		end
		$display("Covered %0d words (directed table plus %0d random phases), %0d checked",
			words_sent, PHASES, results_checked);
		$display("Status: ok %0d rng %0d mis %0d unm %0d map %0d nom %0d seg %0d niu %0d",
			status_hits[ST_OK], status_hits[ST_RANGE], status_hits[ST_MISALIGNED],
			status_hits[ST_UNMAPPED], status_hits[ST_MAPPED], status_hits[ST_NO_MEM],
			status_hits[ST_SEGFAULT], status_hits[ST_NOT_IN_USE]);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
